/* rtl/ccbma_pkg.sv */
package ccbma_pkg;

    // Widest mask the block supports and the width of a CPU count over it.
    localparam int MASK_W  = 64;
    localparam int COUNT_W = 7;
    localparam int ID_W    = 32;
    localparam int VALUE_W = 32;

    localparam logic [COUNT_W-1:0] ONLINE_RESET = 7'd64;

    typedef logic [MASK_W-1:0]  wide_mask_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Per-item status flags carried from the update logic to the result register.
    typedef struct packed {
        logic cpu_invalid;
        logic round_done;
        logic rescan_needed;
    } step_flags_t;

    // Number of set bits in a 64-bit mask, summed pairwise in six levels so
    // that no add waits on more than five others.
    function automatic count_t count_ones(input wide_mask_t mask);
        logic [1:0] sum2  [32];
        logic [2:0] sum4  [16];
        logic [3:0] sum8  [8];
        logic [4:0] sum16 [4];
        logic [5:0] sum32 [2];
        for (int i = 0; i < 32; i++) begin
            sum2[i] = {1'b0, mask[2*i]} + {1'b0, mask[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            sum4[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            sum8[i] = {1'b0, sum4[2*i]} + {1'b0, sum4[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            sum16[i] = {1'b0, sum8[2*i]} + {1'b0, sum8[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            sum32[i] = {1'b0, sum16[2*i]} + {1'b0, sum16[2*i+1]};
        end
        return {1'b0, sum32[0]} + {1'b0, sum32[1]};
    endfunction

endpackage

/* rtl/ccbma_update.sv */
module ccbma_update #(
    parameter int CPU_COUNT = 64
) (
    input  logic [ccbma_pkg::ID_W-1:0]    cpu_id,
    input  logic [ccbma_pkg::VALUE_W-1:0] perf_value,
    input  logic [ccbma_pkg::VALUE_W-1:0] eff_value,
    input  ccbma_pkg::count_t             online_cpu_count,
    input  logic [CPU_COUNT-1:0]          pending_ban,
    input  logic [CPU_COUNT-1:0]          seen_cpus,
    input  logic [CPU_COUNT-1:0]          banned_mask,
    output logic [CPU_COUNT-1:0]          pending_ban_next,
    output logic [CPU_COUNT-1:0]          seen_cpus_next,
    output logic [CPU_COUNT-1:0]          banned_mask_next,
    output ccbma_pkg::step_flags_t        flags
);
    import ccbma_pkg::*;

    localparam int IDX_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    logic                 id_ok;
    logic                 zero_capacity;
    logic [CPU_COUNT-1:0] cpu_bit;
    logic [CPU_COUNT-1:0] pending_marked;
    logic [CPU_COUNT-1:0] seen_marked;
    logic                 round_close;
    logic                 mask_differs;

    assign id_ok         = cpu_id < ID_W'(CPU_COUNT);
    assign zero_capacity = (perf_value == '0) && (eff_value == '0);
    assign cpu_bit       = CPU_COUNT'(1) << cpu_id[IDX_W-1:0];

    assign pending_marked = zero_capacity ? (pending_ban | cpu_bit) : pending_ban;
    assign seen_marked    = seen_cpus | cpu_bit;

    // The round closes once the distinct reporters reach the online count.
    assign round_close  = id_ok && (count_ones(MASK_W'(seen_marked)) >= online_cpu_count);
    assign mask_differs = pending_marked != banned_mask;

    always_comb
    begin
        pending_ban_next = pending_ban;
        seen_cpus_next   = seen_cpus;
        banned_mask_next = banned_mask;
        if (id_ok)
        begin
            if (round_close)
            begin
                pending_ban_next = '0;
                seen_cpus_next   = '0;
                banned_mask_next = pending_marked;
            end
            else
            begin
                pending_ban_next = pending_marked;
                seen_cpus_next   = seen_marked;
            end
        end
    end

    assign flags.cpu_invalid   = !id_ok;
    assign flags.round_done    = round_close;
    assign flags.rescan_needed = round_close && mask_differs;

endmodule

/* rtl/cpu_capacity_ban_mask_aggregator.sv */
// CPU capacity ban-mask aggregator. Each item is one capacity report (CPU number,
// performance value, efficiency value). A CPU reporting zero for both values is
// marked for banning, and every valid reporter is marked as seen. When the number
// of distinct CPUs seen reaches online_cpu_count, the round closes: the pending
// ban mask replaces the banned mask, rescan_needed is raised if it changed, and
// the round state is cleared. A CPU number at or above CPU_COUNT is flagged with
// cpu_invalid and changes nothing. Each item yields exactly one result item that
// carries the banned mask after that report; bits at and above CPU_COUNT read zero.
// The block takes one item per cycle while results are taken: an item sits in an
// input register, passes through the mask update (a 64-bit population count and
// compare), and lands in a result register, from which it is offered on out_valid.
// A stalled result only holds up the input once both registers are full. Write
// online_cpu_count through cfg_wr_en/cfg_wr_data only while no item is in flight;
// it resets to 64.
module cpu_capacity_ban_mask_aggregator #(
    parameter int CPU_COUNT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  ccbma_pkg::count_t             cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ccbma_pkg::ID_W-1:0]    cpu_id,
    input  logic [ccbma_pkg::VALUE_W-1:0] perf_value,
    input  logic [ccbma_pkg::VALUE_W-1:0] eff_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cpu_invalid,
    output logic                          round_done,
    output logic                          rescan_needed,
    output ccbma_pkg::wide_mask_t         banned_now
);
    import ccbma_pkg::*;

    // Configuration.
    count_t online_reg;

    // Input register.
    logic                 in_valid_reg;
    logic [ID_W-1:0]      cpu_id_reg;
    logic [VALUE_W-1:0]   perf_reg;
    logic [VALUE_W-1:0]   eff_reg;

    // Round state.
    logic [CPU_COUNT-1:0] pending_reg;
    logic [CPU_COUNT-1:0] seen_reg;
    logic [CPU_COUNT-1:0] banned_reg;
    logic [CPU_COUNT-1:0] pending_next;
    logic [CPU_COUNT-1:0] seen_next;
    logic [CPU_COUNT-1:0] banned_next;
    step_flags_t          step_flags;

    // Result register.
    logic                 out_valid_reg;
    step_flags_t          flags_reg;
    wide_mask_t           banned_now_reg;

    logic out_free;
    logic advance;

    // The result slot can take a new item when empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    ccbma_update #(
        .CPU_COUNT(CPU_COUNT)
    ) u_update (
        .cpu_id           (cpu_id_reg),
        .perf_value       (perf_reg),
        .eff_value        (eff_reg),
        .online_cpu_count (online_reg),
        .pending_ban      (pending_reg),
        .seen_cpus        (seen_reg),
        .banned_mask      (banned_reg),
        .pending_ban_next (pending_next),
        .seen_cpus_next   (seen_next),
        .banned_mask_next (banned_next),
        .flags            (step_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg    <= ONLINE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            seen_reg      <= '0;
            banned_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                online_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // State moves with the item so the next report sees this one's effect.
            if (advance)
            begin
                pending_reg <= pending_next;
                seen_reg    <= seen_next;
                banned_reg  <= banned_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cpu_id_reg <= cpu_id;
            perf_reg   <= perf_value;
            eff_reg    <= eff_value;
        end
        if (advance)
        begin
            flags_reg      <= step_flags;
            banned_now_reg <= MASK_W'(banned_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign cpu_invalid   = flags_reg.cpu_invalid;
    assign round_done    = flags_reg.round_done;
    assign rescan_needed = flags_reg.rescan_needed;
    assign banned_now    = banned_now_reg;

    // A rescan only ever happens at the close of a round.
    a_rescan_in_round : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!flags_reg.rescan_needed || flags_reg.round_done))
        else $error("rescan_needed without round_done");

    // An ignored report never closes a round.
    a_invalid_no_round : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(flags_reg.cpu_invalid && flags_reg.round_done))
        else $error("invalid report closed a round");

    // Closing a round clears the round state.
    a_round_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_flags.round_done) |=> (seen_reg == '0 && pending_reg == '0))
        else $error("round state not cleared at round close");

    // The banned mask changes only through a reported rescan.
    a_banned_changes : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !step_flags.rescan_needed) |=> $stable(banned_reg))
        else $error("banned mask changed without rescan");

endmodule

/* verif/cpu_capacity_ban_mask_aggregator_tb.sv */
module cpu_capacity_ban_mask_aggregator_tb;

    // The block is built for the full 64-bit mask; every CPU number from 64 up is ignored.
    localparam int CPU_COUNT = 64;

    // Every accepted report produces one result item. The first phases are
    // directed; after that the run walks through many online-count settings
    // until about this many reports have gone in.
    localparam int REPORT_TARGET = 1200;

    // Extra settling wait after the last owed result has come back, used before
    // a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 4;

    // The limit on the whole run. The slowest correct run takes about
    // 1300 items, each held up by at most one receiver stall, plus the
    // sender gaps and the settling around each register write.
    localparam int RUN_LIMIT = 4_000_000;

    // One result item as the block presents it.
    typedef struct packed {
        logic                  cpu_invalid;
        logic                  round_done;
        logic                  rescan_needed;
        ccbma_pkg::wide_mask_t banned_now;
    } ban_report_result_t;

    // Patterns that the receiver cycles through: always ready, randomly
    // choppy, and long runs of stall and ready.
    typedef enum int {
        RX_FREE,
        RX_CHOPPY,
        RX_BLOCKS
    } rx_mode_e;

    // Tracks the round state of the aggregator and keeps the results that
    // are still owed, oldest first.
    class ban_mask_tracker;
        ccbma_pkg::wide_mask_t pending_ban;
        ccbma_pkg::wide_mask_t seen_cpus;
        ccbma_pkg::wide_mask_t banned_mask;
        ccbma_pkg::count_t     online_count;
        ban_report_result_t    owed_results[$];
        int                    mismatches;
        int                    reports_noted;
        int                    rounds_closed;
        int                    rescans;
        int                    ignored_ids;

        function new();
            pending_ban   = '0;
            seen_cpus     = '0;
            banned_mask   = '0;
            online_count  = ccbma_pkg::ONLINE_RESET;
            mismatches    = 0;
            reports_noted = 0;
            rounds_closed = 0;
            rescans       = 0;
            ignored_ids   = 0;
        endfunction

        function void set_online(input ccbma_pkg::count_t value);
            online_count = value;
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        // Applies one accepted report to the round state and queues the
        // result that the block must return for it.
        function void note_report(input logic [31:0] cpu, input logic [31:0] perf,
                                  input logic [31:0] eff);
            ban_report_result_t    r;
            ccbma_pkg::wide_mask_t cpu_bit;
            int                    seen_total;
            r = '0;
            reports_noted++;
            if (cpu >= 32'(CPU_COUNT))
            begin
                // An out-of-range CPU changes nothing and closes no round.
                r.cpu_invalid = 1'b1;
                ignored_ids++;
            end
            else
            begin
                cpu_bit = ccbma_pkg::wide_mask_t'(1) << cpu[5:0];
                if (perf == '0 && eff == '0)
                    pending_ban |= cpu_bit;
                seen_cpus |= cpu_bit;
                seen_total = 0;
                for (int i = 0; i < CPU_COUNT; i++)
                    seen_total += int'(seen_cpus[i]);
                if (seen_total >= int'(online_count))
                begin
                    r.round_done = 1'b1;
                    rounds_closed++;
                    if (pending_ban != banned_mask)
                    begin
                        banned_mask = pending_ban;
                        r.rescan_needed = 1'b1;
                        rescans++;
                    end
                    pending_ban = '0;
                    seen_cpus   = '0;
                end
            end
            r.banned_now = banned_mask;
            owed_results.push_back(r);
        endfunction

        // Compares one delivered result with the oldest owed one.
        function void check_result(input ban_report_result_t got);
            ban_report_result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result item arrived with none owed (banned_now %h)",
                         $time, got.banned_now);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.cpu_invalid !== want.cpu_invalid)
            begin
                $display("%0t: cpu_invalid expected %0b, got %0b",
                         $time, want.cpu_invalid, got.cpu_invalid);
                mismatches++;
            end
            if (got.round_done !== want.round_done)
            begin
                $display("%0t: round_done expected %0b, got %0b",
                         $time, want.round_done, got.round_done);
                mismatches++;
            end
            if (got.rescan_needed !== want.rescan_needed)
            begin
                $display("%0t: rescan_needed expected %0b, got %0b",
                         $time, want.rescan_needed, got.rescan_needed);
                mismatches++;
            end
            if (got.banned_now !== want.banned_now)
            begin
                $display("%0t: banned_now expected %h, got %h",
                         $time, want.banned_now, got.banned_now);
                mismatches++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    ccbma_pkg::count_t             cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [ccbma_pkg::ID_W-1:0]    cpu_id = '0;
    logic [ccbma_pkg::VALUE_W-1:0] perf_value = '0;
    logic [ccbma_pkg::VALUE_W-1:0] eff_value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          cpu_invalid;
    logic                          round_done;
    logic                          rescan_needed;
    ccbma_pkg::wide_mask_t         banned_now;

    ban_mask_tracker tracker;

    // Sender burst state: reports left in the current burst.
    int burst_left = 0;
    int settings_written = 0;

    // Receiver pattern state.
    rx_mode_e rx_mode = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_run_left = 0;
    logic     rx_run_level = 1'b0;

    cpu_capacity_ban_mask_aggregator #(
        .CPU_COUNT(CPU_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cpu_id(cpu_id),
        .perf_value(perf_value),
        .eff_value(eff_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cpu_invalid(cpu_invalid),
        .round_done(round_done),
        .rescan_needed(rescan_needed),
        .banned_now(banned_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("%0t: run did not finish in time, %0d results still owed",
                 $time, tracker.outstanding());
        $display("[FAIL] regression broken");
        $finish;
    end

    // The receiver. The result is checked on the values that the block and
    // the testbench held at the edge, then the next ready level is chosen.
    // The mode is drawn anew whenever its random run ends, so there are long stretches
    // with no stall as well as choppy ones and long holds.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result({cpu_invalid, round_done, rescan_needed, banned_now});
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_e'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(32, 256);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_FREE:
                out_ready <= 1'b1;
            RX_CHOPPY:
                out_ready <= ($urandom_range(0, 2) != 0);
            default:
            begin
                if (rx_run_left == 0)
                begin
                    rx_run_level = ~rx_run_level;
                    rx_run_left  = rx_run_level ? $urandom_range(1, 10) : $urandom_range(1, 24);
                end
                rx_run_left--;
                out_ready <= rx_run_level;
            end
        endcase
    end

    // Offers one report and waits until the block takes it. Reports go out
    // in bursts; between bursts the valid drops for a random gap. Valid is
    // left high after acceptance so the next report of the same burst
    // follows without a bubble.
    task automatic send_report(input logic [31:0] cpu, input logic [31:0] perf,
                               input logic [31:0] eff);
        if (burst_left == 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 9) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid   <= 1'b1;
        cpu_id     <= cpu;
        perf_value <= perf;
        eff_value  <= eff;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_report(cpu, perf, eff);
    endtask

    // Stops the stream and waits until every owed result is back, then waits
    // out SETTLE_CYCLES so that nothing is left in the pipeline.
    task automatic settle_stream();
        if (in_valid)
            in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the online CPU count while the block is idle.
    task automatic write_online(input ccbma_pkg::count_t value);
        settle_stream();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_online(value);
        settings_written++;
    endtask

    // Performance and efficiency for one report: both zero for a CPU to be
    // banned, otherwise random values where at most one of the two is zero.
    function automatic logic [63:0] capacity_pair(input bit zero_both);
        logic [31:0] perf;
        logic [31:0] eff;
        if (zero_both)
            return 64'd0;
        perf = $urandom;
        eff  = $urandom;
        case ($urandom_range(0, 3))
            0: perf = '0;
            1: eff = '0;
            default: ;
        endcase
        if (perf == '0 && eff == '0)
            eff = 32'd1;
        return {perf, eff};
    endfunction

    // A CPU number the block must ignore: either just above the mask or
    // anywhere in the 32-bit range.
    function automatic logic [31:0] bad_cpu_id();
        logic [31:0] id;
        if ($urandom_range(0, 1) == 1)
            id = $urandom;
        else
            id = 32'($urandom_range(64, 127));
        if (id < 32'(CPU_COUNT))
            id = id + 32'(CPU_COUNT);
        return id;
    endfunction

    // One well-formed round: the given number of distinct CPUs in random
    // order, banned according to the ban set. About one report in ten is
    // noise: an ignored CPU number or a repeat of a CPU already seen.
    task automatic run_round(input int reports, input ccbma_pkg::wide_mask_t ban_set);
        int          order [CPU_COUNT];
        int          j;
        int          tmp;
        int          pick;
        logic [63:0] vals;
        for (int k = 0; k < CPU_COUNT; k++)
            order[k] = k;
        for (int k = CPU_COUNT - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < reports; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                vals = capacity_pair($urandom_range(0, 1) == 1);
                if (k > 0 && $urandom_range(0, 1) == 1)
                begin
                    pick = order[$urandom_range(0, k - 1) % CPU_COUNT];
                    send_report(32'(pick), vals[63:32], vals[31:0]);
                end
                else
                    send_report(bad_cpu_id(), vals[63:32], vals[31:0]);
            end
            pick = order[k % CPU_COUNT];
            vals = capacity_pair(ban_set[pick]);
            send_report(32'(pick), vals[63:32], vals[31:0]);
        end
    endtask

    // Random CPUs with no attempt to complete a round, used when the online
    // count can never be reached.
    task automatic run_scatter(input int reports);
        logic [63:0] vals;
        for (int k = 0; k < reports; k++)
        begin
            vals = capacity_pair($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                send_report(bad_cpu_id(), vals[63:32], vals[31:0]);
            else
                send_report(32'($urandom_range(0, CPU_COUNT - 1)), vals[63:32], vals[31:0]);
        end
    endtask

    initial
    begin
        ccbma_pkg::count_t     online;
        ccbma_pkg::wide_mask_t ban_set;
        int                    pick;
        int                    rounds;

        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset count of 64. A banned CPU,
        // the top CPU with all-ones values, ignored CPU numbers at the first
        // invalid value and at all ones, a repeat that must not clear a ban,
        // and reports where only one of the two values is zero.
        send_report(32'd0, 32'd0, 32'd0);
        send_report(32'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_report(32'd64, 32'd0, 32'd0);
        send_report(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_report(32'd0, 32'd1, 32'd1);
        send_report(32'd1, 32'd0, 32'd5);
        send_report(32'd2, 32'd7, 32'd0);
        send_report(32'd32, 32'd0, 32'd0);

        // A count of one with five CPUs already seen closes the round on the
        // next report. The same ban twice in a row must not ask for a rescan.
        write_online(ccbma_pkg::count_t'(1));
        send_report(32'd5, 32'd0, 32'd0);
        send_report(32'd5, 32'd0, 32'd0);
        send_report(32'd5, 32'd0, 32'd0);

        // A count of zero: every valid report closes a round, but an ignored
        // one does not.
        write_online(ccbma_pkg::count_t'(0));
        send_report(32'd7, 32'h8000_0000, 32'd1);
        send_report(32'd128, 32'd0, 32'd0);

        // The largest count can never be reached, so state only piles up.
        write_online(ccbma_pkg::count_t'(127));
        send_report(32'd10, 32'd0, 32'd0);
        send_report(32'd11, 32'd2, 32'd3);
        send_report(32'd10, 32'd4, 32'd4);

        // Random part. Each phase picks an online count, mostly small so
        // that rounds close often, sometimes the full 64, and now and then
        // zero or one out of reach. Rounds within a phase reuse the same ban set
        // about half the time, so unchanged masks that must not trigger a rescan
        // are as common as changed ones.
        ban_set = '0;
        while (tracker.reports_noted < REPORT_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                online = '0;
            else if (pick < 8)
                online = ccbma_pkg::count_t'($urandom_range(CPU_COUNT + 1, 127));
            else if (pick < 16)
                online = ccbma_pkg::count_t'(CPU_COUNT);
            else if (pick < 22)
                online = ccbma_pkg::count_t'(1);
            else
                online = ccbma_pkg::count_t'($urandom_range(2, 16));
            write_online(online);

            if (int'(online) > CPU_COUNT)
                run_scatter($urandom_range(10, 40));
            else
            begin
                rounds = (int'(online) == CPU_COUNT) ? 1 : $urandom_range(1, 4);
                for (int r = 0; r < rounds; r++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        ban_set = '0;
                    else if (pick == 1)
                        ban_set = '1;
                    else if (pick < 5)
                        ban_set = {$urandom, $urandom} & {$urandom, $urandom};
                    if (online == '0)
                        run_round($urandom_range(1, 4), ban_set);
                    else
                        run_round(int'(online), ban_set);
                end
            end
        end

        settle_stream();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("Sent %0d capacity reports over %0d online-count settings.",
                 tracker.reports_noted, settings_written);
        $display("Saw %0d rounds close, %0d ban mask changes and %0d ignored CPU numbers.",
                 tracker.rounds_closed, tracker.rescans, tracker.ignored_ids);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/ccbma_pkg.sv
rtl/ccbma_update.sv
rtl/cpu_capacity_ban_mask_aggregator.sv
verif/cpu_capacity_ban_mask_aggregator_tb.sv
